@@ sv/stk_pkg.sv @@
// Shared constants, codes and record types of the script tokenizer.
package stk_pkg;

    // Token length limit: a token keeps at most TOKEN_CHARS-1 bytes.
    localparam int TOKEN_CHARS = 1024;
    localparam int LEN_W       = $clog2(TOKEN_CHARS);
    localparam logic [LEN_W-1:0] KEEP_MAX = LEN_W'(TOKEN_CHARS - 1);

    // Port field widths.
    localparam int BYTE_W    = 8;
    localparam int OUT_LEN_W = 10;
    localparam int LINE_W    = 16;
    localparam int OUT_DATA_W = 40;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Results one text byte can cause, and depth of the result queue.
    localparam int RES_MAX     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Scan modes.
    localparam logic [2:0] M_SKIP  = 3'd0;
    localparam logic [2:0] M_SLASH = 3'd1;
    localparam logic [2:0] M_LINE  = 3'd2;
    localparam logic [2:0] M_BLOCK = 3'd3;
    localparam logic [2:0] M_STAR  = 3'd4;
    localparam logic [2:0] M_QUOTE = 3'd5;
    localparam logic [2:0] M_WORD  = 3'd6;

    // Result kinds.
    typedef logic [1:0] kind_t;
    localparam kind_t K_BYTE  = 2'd0;
    localparam kind_t K_END   = 2'd1;
    localparam kind_t K_BREAK = 2'd2;
    localparam kind_t K_EOD   = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_EOD   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SEP   = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // One result of a text byte.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] tok;
        logic [LEN_W-1:0]  len;
    } res_t;

    // All results of one text byte, as queued between front and back.
    typedef struct packed {
        logic [1:0]                count;
        res_t [RES_MAX-1:0]        res;
        logic [LINE_W-1:0]         lines;
    } bundle_t;

endpackage

@@ sv/script_tokenizer.sv @@
// Top level of the streaming script tokenizer.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata: text_byte; s_tuser: new_session
//  m_       out  m_tvalid / m_tready    m_tdata: token_byte, token_length, line_count;
//                                       m_tuser: kind; m_tlast: last
//  cfg_     in   cfg_valid / cfg_ready  cfg_data: allow_line_breaks
//
// The scan state updates in the cycle a byte is accepted, so one byte enters per cycle.
// Each byte yields zero to three results, which wait in a four-bundle queue and leave
// at one result per cycle while m_tready is high; the output side therefore sets the sustained rate.
// Input is stalled only while the queue is full. Reset clears the scan state, the
// line count and the queue, and sets allow_line_breaks to 1.
module script_tokenizer
    import stk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] text_byte
    input  logic                    s_tuser,   // [0] new_session
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,   // [7:0] token_byte, [17:8] token_length,
                                               // [33:18] line_count, [39:34] zero
    output logic [1:0]              m_tuser,   // [1:0] kind
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    full;
    logic    not_empty;
    bundle_t push_data;
    bundle_t head;

    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Scan and classify.
    stk_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_tdata),
        .new_session (s_tuser),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_value   (cfg_data),
        .push        (push),
        .bundle      (push_data)
    );

    // Decouple the two sides.
    stk_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    // Send results.
    stk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ sv/stk_front.sv @@
// Front end: scan state machine that classifies each text byte into results.
module stk_front
    import stk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [BYTE_W-1:0]   text_byte,
    input  logic                new_session,
    input  logic                cfg_write,
    input  logic                cfg_value,
    output logic                push,
    output bundle_t             bundle
);

    logic [2:0]        mode_reg, mode_next;
    logic              saw_nl_reg, saw_nl_next;
    logic [LEN_W-1:0]  klen_reg, klen_next;
    logic [LINE_W-1:0] lines_reg, lines_next;
    logic              allow_reg;

    res_t [RES_MAX-1:0] res;
    logic [1:0]         n;
    logic               word_step;

    // Per-byte state update and result generation.
    always_comb
    begin
        mode_next   = new_session ? M_SKIP : mode_reg;
        saw_nl_next = new_session ? 1'b0 : saw_nl_reg;
        klen_next   = new_session ? '0 : klen_reg;
        lines_next  = new_session ? '0 : lines_reg;
        res         = '0;
        n           = 2'd0;
        word_step   = 1'b0;

        unique case (mode_next)
            M_SLASH:
            begin
                if (text_byte == CH_SLASH)
                begin
                    mode_next = M_LINE;
                end
                else if (text_byte == CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
                else
                begin
                    // The lone slash starts a word; this byte continues or closes it.
                    mode_next   = M_WORD;
                    saw_nl_next = 1'b0;
                    klen_next   = LEN_W'(1);
                    res[n]      = '{K_BYTE, CH_SLASH, klen_next};
                    n           = n + 2'd1;
                    word_step   = 1'b1;
                end
            end
            M_LINE:
            begin
                if (text_byte == CH_EOD)
                begin
                    res[n]      = '{K_EOD, '0, '0};
                    n           = n + 2'd1;
                    mode_next   = M_SKIP;
                    saw_nl_next = 1'b0;
                    klen_next   = '0;
                end
                else if (text_byte == CH_NL)
                begin
                    mode_next   = M_SKIP;
                    saw_nl_next = 1'b1;
                    if (lines_next != LINE_MAX)
                    begin
                        lines_next = lines_next + 1'b1;
                    end
                end
            end
            M_BLOCK, M_STAR:
            begin
                if (text_byte == CH_EOD)
                begin
                    res[n]      = '{K_EOD, '0, '0};
                    n           = n + 2'd1;
                    mode_next   = M_SKIP;
                    saw_nl_next = 1'b0;
                    klen_next   = '0;
                end
                else if (mode_next == M_BLOCK)
                begin
                    if (text_byte == CH_STAR)
                    begin
                        mode_next = M_STAR;
                    end
                end
                else if (text_byte == CH_SLASH)
                begin
                    mode_next = M_SKIP;
                end
                else if (text_byte != CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
            end
            M_QUOTE:
            begin
                if (text_byte == CH_EOD || text_byte == CH_QUOTE)
                begin
                    res[n]      = '{K_END, '0, klen_next};
                    n           = n + 2'd1;
                    klen_next   = '0;
                    saw_nl_next = 1'b0;
                    mode_next   = M_SKIP;
                    if (text_byte == CH_EOD)
                    begin
                        res[n] = '{K_EOD, '0, '0};
                        n      = n + 2'd1;
                    end
                end
                else if (klen_next < KEEP_MAX)
                begin
                    klen_next = klen_next + 1'b1;
                    res[n]    = '{K_BYTE, text_byte, klen_next};
                    n         = n + 2'd1;
                end
            end
            M_WORD:
            begin
                word_step = 1'b1;
            end
            default:
            begin
                // Skipping whitespace; also serves the unused mode code.
                if (text_byte == CH_EOD)
                begin
                    res[n]      = '{K_EOD, '0, '0};
                    n           = n + 2'd1;
                    mode_next   = M_SKIP;
                    saw_nl_next = 1'b0;
                    klen_next   = '0;
                end
                else if (text_byte <= CH_SEP)
                begin
                    mode_next = M_SKIP;
                    if (text_byte == CH_NL)
                    begin
                        saw_nl_next = 1'b1;
                        if (lines_next != LINE_MAX)
                        begin
                            lines_next = lines_next + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (saw_nl_next && !allow_reg)
                    begin
                        res[n]      = '{K_BREAK, '0, '0};
                        n           = n + 2'd1;
                        saw_nl_next = 1'b0;
                    end
                    if (text_byte == CH_SLASH)
                    begin
                        mode_next = M_SLASH;
                    end
                    else
                    begin
                        mode_next   = (text_byte == CH_QUOTE) ? M_QUOTE : M_WORD;
                        klen_next   = '0;
                        saw_nl_next = 1'b0;
                        if (text_byte != CH_QUOTE)
                        begin
                            klen_next = LEN_W'(1);
                            res[n]    = '{K_BYTE, text_byte, klen_next};
                            n         = n + 2'd1;
                        end
                    end
                end
            end
        endcase

        // Continue or close a word with this byte.
        if (word_step)
        begin
            if (text_byte <= CH_SEP)
            begin
                res[n]      = '{K_END, '0, klen_next};
                n           = n + 2'd1;
                klen_next   = '0;
                saw_nl_next = 1'b0;
                mode_next   = M_SKIP;
                if (text_byte == CH_EOD)
                begin
                    res[n] = '{K_EOD, '0, '0};
                    n      = n + 2'd1;
                end
                else if (text_byte == CH_NL)
                begin
                    saw_nl_next = 1'b1;
                    if (lines_next != LINE_MAX)
                    begin
                        lines_next = lines_next + 1'b1;
                    end
                end
            end
            else if (klen_next < KEEP_MAX)
            begin
                klen_next = klen_next + 1'b1;
                res[n]    = '{K_BYTE, text_byte, klen_next};
                n         = n + 2'd1;
            end
        end
    end

    assign push   = accept && (n != 2'd0);
    assign bundle = '{n, res, lines_next};

    // Scan state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_SKIP;
            saw_nl_reg <= 1'b0;
            klen_reg   <= '0;
            lines_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            saw_nl_reg <= saw_nl_next;
            klen_reg   <= klen_next;
            lines_reg  <= lines_next;
        end
    end

    // Line-break register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            allow_reg <= cfg_value;
        end
    end

endmodule

@@ sv/stk_queue.sv @@
// Short queue of per-byte result bundles between front and back.
module stk_queue
    import stk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output bundle_t head
);

    bundle_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     cnt_reg, cnt_next;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/stk_back.sv @@
// Back end: sends the results of the head bundle one request at a time.
module stk_back
    import stk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  bundle_t                 head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    logic [1:0] idx_reg, idx_next;
    res_t       cur;
    logic       send;

    assign cur      = head.res[idx_reg];
    assign m_tvalid = head_valid;
    assign m_tlast  = (idx_reg == head.count - 2'd1);
    assign m_tuser  = cur.kind;
    assign m_tdata  = {(OUT_DATA_W - BYTE_W - OUT_LEN_W - LINE_W)'(0), head.lines,
                       OUT_LEN_W'(cur.len), cur.tok};
    assign send     = m_tvalid && m_tready;
    assign pop      = send && m_tlast;

    // Walk through the bundle's results.
    always_comb
    begin
        idx_next = idx_reg;
        if (send)
        begin
            idx_next = m_tlast ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ dv/tb_script_tokenizer.sv @@
// Self-checking testbench of the streaming script tokenizer, with its own token predictor.
module tb_script_tokenizer;
    import stk_pkg::*;

    localparam int PAD_W           = OUT_DATA_W - BYTE_W - OUT_LEN_W - LINE_W;
    localparam int DIRECTED_ROWS   = 26;
    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 86;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 500_000;
    localparam int REPORT_MAX      = 10;

    // Idling per phase, in percent: none, sender, receiver, both.
    localparam int SEND_IDLE [PHASES] = '{0, 74, 0, 20};
    localparam int RECV_STALL[PHASES] = '{0, 0, 74, 20};

    // One result as it appears on the output stream.
    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    tok;
        logic [OUT_LEN_W-1:0] len;
        logic [LINE_W-1:0]    lines;
        logic                 last;
        logic [PAD_W-1:0]     pad;
    } token_t;

    // Typed-in expectation that replaces the prediction for one text byte.
    typedef struct packed {
        logic   typed;
        token_t res;
    } token_hint_t;

    // One row of the directed text.
    typedef struct packed {
        logic [7:0]           ch;
        logic                 ns;
        logic                 typed;
        kind_t                kind;
        logic [BYTE_W-1:0]    tok;
        logic [OUT_LEN_W-1:0] len;
        logic [LINE_W-1:0]    lines;
    } text_row_t;

    localparam text_row_t DIRECTED_TEXT [DIRECTED_ROWS] = '{
        // End of data right after reset, with a new session.
        '{CH_EOD,   1'b1, 1'b1, K_EOD,  8'h00, 10'd0, 16'd0},
        // A word with the byte 0x41 and the highest word byte, ended by a newline.
        '{8'h41,    1'b0, 1'b1, K_BYTE, 8'h41, 10'd1, 16'd0},
        '{8'hFF,    1'b0, 1'b1, K_BYTE, 8'hFF, 10'd2, 16'd0},
        '{CH_NL,    1'b0, 1'b1, K_END,  8'h00, 10'd2, 16'd1},
        // Line comment; its closing newline is counted.
        '{CH_SLASH, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_SLASH, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{8'h78,    1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_NL,    1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        // Block comment holding a newline and a run of stars.
        '{CH_SLASH, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_STAR,  1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_NL,    1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_STAR,  1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_STAR,  1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_SLASH, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        // Quoted string that keeps a separator.
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_SEP,   1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        // Empty string.
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_QUOTE, 1'b0, 1'b1, K_END,  8'h00, 10'd0, 16'd2},
        // Lone slash starting a word, closed by the lowest separator.
        '{CH_SLASH, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{8'h71,    1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{8'h01,    1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        // Lone slash cut by end of data: three results from one byte.
        '{CH_SLASH, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_EOD,   1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        // Open string cut by end of data.
        '{CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0},
        '{CH_EOD,   1'b0, 1'b0, K_BYTE, 8'h00, 10'd0, 16'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    // Predictor state.
    logic [2:0]        scan_st;
    logic              nl_pending;
    logic [LEN_W-1:0]  tok_len;
    logic [LINE_W-1:0] line_cnt;
    logic              breaks_ok;

    token_t      byte_tokens[$];
    token_t      expected_tokens[$];
    token_hint_t token_hints[$];

    int idle_pct;
    int stall_pct;
    int text_bytes_sent;
    int mismatch_count;
    int cycles;

    script_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_token(kind_t k, logic [7:0] b, logic [LEN_W-1:0] n);
        token_t r;
        if (byte_tokens.size() < RES_MAX)
        begin
            r       = '0;
            r.kind  = k;
            r.tok   = b;
            r.len   = OUT_LEN_W'(n);
            byte_tokens.push_back(r);
        end
    endfunction

    // Keep a byte unless the token is already at its length limit.
    function automatic void keep_byte(logic [7:0] c);
        if (tok_len < KEEP_MAX)
        begin
            tok_len++;
            add_token(K_BYTE, c, tok_len);
        end
    endfunction

    function automatic void close_token();
        add_token(K_END, 8'h00, tok_len);
        tok_len    = '0;
        nl_pending = 1'b0;
        scan_st    = M_SKIP;
    endfunction

    function automatic void close_data();
        add_token(K_EOD, 8'h00, '0);
        scan_st    = M_SKIP;
        nl_pending = 1'b0;
        tok_len    = '0;
    endfunction

    // A separator; only a newline here bumps the saturating line count.
    function automatic void take_separator(logic [7:0] c);
        scan_st = M_SKIP;
        if (c == CH_NL)
        begin
            if (line_cnt != LINE_MAX)
                line_cnt++;
            nl_pending = 1'b1;
        end
    endfunction

    function automatic void open_word(logic [7:0] c);
        scan_st    = M_WORD;
        tok_len    = '0;
        nl_pending = 1'b0;
        keep_byte(c);
    endfunction

    function automatic void word_step(logic [7:0] c);
        if (c == CH_EOD)
        begin
            close_token();
            close_data();
        end
        else if (c <= CH_SEP)
        begin
            close_token();
            take_separator(c);
        end
        else
            keep_byte(c);
    endfunction

    // Work out every result of one accepted text byte into byte_tokens.
    function automatic void predict_tokens(logic [7:0] c, logic ns);
        int k;
        byte_tokens.delete();
        if (ns)
        begin
            scan_st    = M_SKIP;
            nl_pending = 1'b0;
            tok_len    = '0;
            line_cnt   = '0;
        end
        case (scan_st)
            M_SLASH:
            begin
                if (c == CH_SLASH)
                    scan_st = M_LINE;
                else if (c == CH_STAR)
                    scan_st = M_BLOCK;
                else
                begin
                    open_word(CH_SLASH);
                    word_step(c);
                end
            end
            M_LINE:
            begin
                if (c == CH_EOD)
                    close_data();
                else if (c == CH_NL)
                    take_separator(c);
            end
            M_BLOCK:
            begin
                if (c == CH_EOD)
                    close_data();
                else if (c == CH_STAR)
                    scan_st = M_STAR;
            end
            M_STAR:
            begin
                if (c == CH_EOD)
                    close_data();
                else if (c == CH_SLASH)
                    scan_st = M_SKIP;
                else if (c != CH_STAR)
                    scan_st = M_BLOCK;
            end
            M_QUOTE:
            begin
                if (c == CH_EOD)
                begin
                    close_token();
                    close_data();
                end
                else if (c == CH_QUOTE)
                    close_token();
                else
                    keep_byte(c);
            end
            M_WORD:
                word_step(c);
            default:
            begin
                if (c == CH_EOD)
                    close_data();
                else if (c <= CH_SEP)
                    take_separator(c);
                else
                begin
                    // A token start after a newline run, with line breaks disallowed.
                    if (nl_pending && !breaks_ok)
                    begin
                        add_token(K_BREAK, 8'h00, '0);
                        nl_pending = 1'b0;
                    end
                    if (c == CH_SLASH)
                        scan_st = M_SLASH;
                    else if (c == CH_QUOTE)
                    begin
                        scan_st    = M_QUOTE;
                        tok_len    = '0;
                        nl_pending = 1'b0;
                    end
                    else
                        open_word(c);
                end
            end
        endcase
        for (k = 0; k < byte_tokens.size(); k++)
        begin
            byte_tokens[k].lines = line_cnt;
            byte_tokens[k].last  = (k == byte_tokens.size() - 1);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic string token_text(token_t r);
        return $sformatf("kind %0d byte %h len %0d lines %0d last %0d pad %h",
                         r.kind, r.tok, r.len, r.lines, r.last, r.pad);
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // Predict on each input request, check each output request, track the register.
    always @(posedge clk)
    begin
        token_hint_t hint;
        token_t      got;
        token_t      want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                breaks_ok = cfg_data;
            if (s_tvalid && s_tready)
            begin
                predict_tokens(s_tdata, s_tuser);
                hint = token_hints.pop_front();
                if (hint.typed)
                    expected_tokens.push_back(hint.res);
                else
                    foreach (byte_tokens[k])
                        expected_tokens.push_back(byte_tokens[k]);
            end
            if (m_tvalid && m_tready)
            begin
                got.kind  = m_tuser;
                got.tok   = m_tdata[BYTE_W-1:0];
                got.len   = m_tdata[BYTE_W +: OUT_LEN_W];
                got.lines = m_tdata[BYTE_W+OUT_LEN_W +: LINE_W];
                got.last  = m_tlast;
                got.pad   = m_tdata[OUT_DATA_W-1 -: PAD_W];
                if (expected_tokens.size() == 0)
                    note_failure({"unexpected result: ", token_text(got)});
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                        note_failure({"result mismatch: expected ", token_text(want),
                                      ", got ", token_text(got)});
                end
            end
        end
    end

    // Receiver stalls at the rate of the current phase.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one text byte after a random gap and wait for its request to be taken.
    task automatic send_text_byte(input logic [7:0] ch, input logic ns,
                                  input logic typed, input token_t typed_res);
        token_hint_t hint;
        hint.typed = typed;
        hint.res   = typed_res;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        token_hints.push_back(hint);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= ns;
        do
            @(posedge clk);
        while (!s_tready);
        text_bytes_sent++;
    endtask

    // Given text byte, now and then opening a new session.
    task automatic send_byte(input logic [7:0] ch);
        send_text_byte(ch, ($urandom_range(99) < 2), 1'b0, '0);
    endtask

    // Stop sending and wait until every expected result is out and the block is quiet.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_breaks(input logic allow);
        cfg_valid <= 1'b1;
        cfg_data  <= allow;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] word_char();
        return 8'($urandom_range(33, 255));
    endfunction

    function automatic logic [7:0] sep_char();
        if ($urandom_range(2) == 0)
            return CH_NL;
        return 8'($urandom_range(1, 32));
    endfunction

    // One random piece of text, mostly well formed.
    task automatic send_random_piece();
        int         n;
        int         i;
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            // Plain word.
            do
                c = word_char();
            while (c == CH_SLASH || c == CH_QUOTE);
            send_byte(c);
            n = $urandom_range(6);
            for (i = 0; i < n; i++)
                send_byte(word_char());
        end
        else if (pick < 42)
        begin
            // Quoted string, sometimes left open.
            send_byte(CH_QUOTE);
            n = $urandom_range(5);
            for (i = 0; i < n; i++)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_QUOTE);
                send_byte(c);
            end
            if ($urandom_range(9) != 0)
                send_byte(CH_QUOTE);
        end
        else if (pick < 50)
        begin
            // Line comment.
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            n = $urandom_range(4);
            for (i = 0; i < n; i++)
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (c == CH_NL);
                send_byte(c);
            end
            send_byte(CH_NL);
        end
        else if (pick < 58)
        begin
            // Block comment with stars and newlines inside.
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            n = $urandom_range(5);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(3))
                    0:       c = CH_STAR;
                    1:       c = CH_NL;
                    default: c = 8'($urandom_range(1, 255));
                endcase
                send_byte(c);
            end
            send_byte(CH_STAR);
            send_byte(CH_SLASH);
        end
        else if (pick < 63)
        begin
            // Lone slash followed by a word byte or a separator.
            send_byte(CH_SLASH);
            if ($urandom_range(1) == 0)
                send_byte(sep_char());
            else
            begin
                do
                    c = word_char();
                while (c == CH_SLASH || c == CH_STAR);
                send_byte(c);
            end
        end
        else if (pick < 83)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                send_byte(sep_char());
        end
        else if (pick < 88)
            send_byte(CH_EOD);
        else
            send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        token_t t;
        int     i;
        int     ph;
        int     target;

        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        text_bytes_sent = 0;
        mismatch_count  = 0;
        cycles          = 0;
        scan_st         = M_SKIP;
        nl_pending      = 1'b0;
        tok_len         = '0;
        line_cnt        = '0;
        breaks_ok       = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text, with line breaks allowed as after reset.
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            t       = '0;
            t.kind  = DIRECTED_TEXT[i].kind;
            t.tok   = DIRECTED_TEXT[i].tok;
            t.len   = DIRECTED_TEXT[i].len;
            t.lines = DIRECTED_TEXT[i].lines;
            t.last  = 1'b1;
            send_text_byte(DIRECTED_TEXT[i].ch, DIRECTED_TEXT[i].ns, DIRECTED_TEXT[i].typed, t);
        end

        // Random text under each idling pattern, alternating the line-break setting.
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            write_line_breaks(ph[0]);
            idle_pct  = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            target    = text_bytes_sent + ITEMS_PER_PHASE;
            while (text_bytes_sent < target)
                send_random_piece();
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
